// ===== sv/srbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbd_pkg: shared types and constants for the score reel bank driver
// Reel record, command and operation codes, control bundles and widths.
// ----------------------------------------------------------------------------
package srbd_pkg;

	localparam int MAX_REELS   = 8;
	localparam int IDX_W       = $clog2(MAX_REELS);
	localparam int CNT_W       = $clog2(MAX_REELS + 1);
	localparam int DIGIT_W     = 4;
	localparam int BASE_W      = DIGIT_W + 1;
	localparam int PULSE_W     = 16;
	localparam int STEP_W      = 8;
	localparam int AMOUNT_W    = 32;
	localparam int DIV_BITS    = 8;
	localparam int DIV_CYCLES  = AMOUNT_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

	// register indexes of the write port
	localparam logic [1:0] REG_REELS_IN_USE    = 2'd0;
	localparam logic [1:0] REG_TOP_DIGIT       = 2'd1;
	localparam logic [1:0] REG_STEPS_PER_DIGIT = 2'd2;

	// signed carry between neighbor reels
	localparam logic [1:0] CARRY_NONE = 2'b00;
	localparam logic [1:0] CARRY_UP   = 2'b01;
	localparam logic [1:0] CARRY_DOWN = 2'b11;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_SET   = 3'd2,
		CMD_ZERO  = 3'd3,
		CMD_SPIN  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0,
		OP_ADD  = 3'd1,
		OP_SET  = 3'd2,
		OP_ZERO = 3'd3,
		OP_SPIN = 3'd4,
		OP_NONE = 3'd5
	} op_t;

	typedef struct packed {
		logic [DIGIT_W-1:0]        digit;
		logic signed [PULSE_W-1:0] pulse;
		logic [STEP_W-1:0]         cnt;
	} reel_t;

	typedef struct packed {
		op_t                       op;
		logic [1:0]                carry;
		logic [DIGIT_W-1:0]        dv;
		logic                      neg;
		logic signed [PULSE_W-1:0] delta;
		logic [DIGIT_W-1:0]        top;
		logic [BASE_W-1:0]         base;
		logic [STEP_W-1:0]         steps;
	} alu_ctrl_t;

	typedef struct packed {
		reel_t      reel;
		logic       click;
		logic [1:0] carry;
	} alu_res_t;

endpackage

// ===== sv/srbd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbd_div: iterative divider by the reel base
// Restoring division of a 32-bit magnitude by a 5-bit base, eight bits a cycle.
// ----------------------------------------------------------------------------
module srbd_div import srbd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [AMOUNT_W-1:0] dividend,
	input  logic [BASE_W-1:0]   base,
	output logic                done,
	output logic [AMOUNT_W-1:0] quotient,
	output logic [DIGIT_W-1:0]  remainder
);

	logic [AMOUNT_W-1:0]  work_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [AMOUNT_W-1:0]  work_n;
	logic [DIGIT_W-1:0]   rem_n;
	logic [BASE_W-1:0]    trial;

	// shift in one dividend bit per step, subtract the base when it fits
	always_comb begin
		work_n = work_q;
		rem_n  = rem_q;
		trial  = '0;
		for (int k = 0; k < DIV_BITS; k++) begin
			trial  = {rem_n, work_n[AMOUNT_W-1]};
			work_n = {work_n[AMOUNT_W-2:0], 1'b0};
			if (trial >= base) begin
				trial     = trial - base;
				work_n[0] = 1'b1;
			end
			rem_n = trial[DIGIT_W-1:0];
		end
	end

	// sequence the passes over the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold the working value and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	assign done      = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

// ===== sv/srbd_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbd_alu: shared reel update unit
// Computes the new state of one reel for tick, add, set, zero and spin.
// ----------------------------------------------------------------------------
module srbd_alu import srbd_pkg::*; (
	input  alu_ctrl_t ctrl,
	input  reel_t     reel_in,
	output alu_res_t  res
);

	logic signed [PULSE_W:0]   opnd;
	logic signed [PULSE_W+1:0] sum;
	logic signed [PULSE_W-1:0] p1;
	logic                      clk_start;
	logic [STEP_W-1:0]         cd1;
	logic [STEP_W-1:0]         cd2;
	logic [BASE_W-1:0]         dp;
	logic signed [BASE_W:0]    adj;

	// pick the operand of the saturating pulse adder
	always_comb begin
		case (ctrl.op)
			OP_TICK: opnd = {{(PULSE_W - 1){ctrl.carry[1]}}, ctrl.carry};
			OP_ADD:  opnd = ctrl.neg ? -{{(PULSE_W - DIGIT_W + 1){1'b0}}, ctrl.dv}
			                         :  {{(PULSE_W - DIGIT_W + 1){1'b0}}, ctrl.dv};
			OP_SPIN: opnd = {ctrl.delta[PULSE_W-1], ctrl.delta};
			default: opnd = '0;
		endcase
		sum = {{2{reel_in.pulse[PULSE_W-1]}}, reel_in.pulse} + {opnd[PULSE_W], opnd};
		if (sum > (PULSE_W+2)'(32767))
			p1 = 16'sh7FFF;
		else if (sum < -(PULSE_W+2)'(32768))
			p1 = 16'sh8000;
		else
			p1 = sum[PULSE_W-1:0];
	end

	// apply the operation to the reel
	always_comb begin
		res       = '0;
		res.reel  = reel_in;
		clk_start = 1'b0;
		cd1       = '0;
		cd2       = '0;
		dp        = '0;
		adj       = '0;
		case (ctrl.op)
			OP_TICK: begin
				clk_start     = (p1 != 0) && (reel_in.cnt == 0);
				cd1           = clk_start ? ctrl.steps : reel_in.cnt;
				res.click     = clk_start;
				res.reel.pulse = p1;
				res.reel.cnt  = cd1;
				if (cd1 != 0) begin
					cd2          = cd1 - 1'b1;
					res.reel.cnt = cd2;
					if (cd2 == 0) begin
						if (p1 < 0) begin
							res.reel.pulse = p1 + 16'sd1;
							if (reel_in.digit == 0) begin
								res.reel.digit = ctrl.top;
								res.carry      = CARRY_DOWN;
							end else begin
								res.reel.digit = reel_in.digit - 1'b1;
							end
						end else begin
							res.reel.pulse = p1 - 16'sd1;
							dp = {1'b0, reel_in.digit} + 1'b1;
							if (dp > {1'b0, ctrl.top}) begin
								dp             = dp - ctrl.base;
								res.reel.digit = dp[DIGIT_W-1:0];
								res.carry      = CARRY_UP;
							end else begin
								res.reel.digit = dp[DIGIT_W-1:0];
							end
						end
					end
				end
			end
			OP_ADD, OP_SPIN: begin
				res.reel.pulse = p1;
			end
			OP_SET: begin
				res.reel.digit = ctrl.dv;
				res.reel.pulse = '0;
				res.reel.cnt   = '0;
			end
			OP_ZERO: begin
				// a reel at zero with no borrow from the right stays put
				if (ctrl.carry[0] || (reel_in.digit != 0)) begin
					adj = $signed({1'b0, ctrl.base}) - $signed({5'b0, ctrl.carry[0]})
					    - $signed({2'b0, reel_in.digit});
					res.reel.pulse = {{(PULSE_W - BASE_W - 1){adj[BASE_W]}}, adj};
					res.carry      = CARRY_UP;
				end
			end
			default: begin
				res.reel = reel_in;
			end
		endcase
	end

endmodule

// ===== sv/score_reel_bank_driver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// score_reel_bank_driver: bank of electromechanical score reels
// Sequencer, reel storage and result register around the shared update unit.
// ----------------------------------------------------------------------------
// Usage:
//   Send one command request on the s_ channel: s_tuser carries the command,
//   s_tdata the amount, reel number and pulse delta. The block answers with
//   one result per reel in use on the m_ channel, leftmost reel first, with
//   m_tlast on the result for the rightmost reel and m_tuser as status.
//   The user writes configuration registers via cfg_we/cfg_index/cfg_wdata
//   only while no request is in flight; the block does not enforce this.
// Timing:
//   Tick and reset-to-zero walk the reels right to left, one reel a cycle
//   through the shared update unit, then report the reels on the output.
//   Add and set run the base divider once per reel, 4 passes of 8 bits each,
//   with a handoff through the DSTART and DWAIT states before each division.
//   Spin passes through its SPIN state before output.
//   s_tready is high only while the sequencer is idle.
// Reset and stall:
//   Reset clears all reels and loads the register defaults (5, 9, 2).
//   A stalled m_tready holds the result register; the sequencer waits and the
//   next request can be taken while the final result is still waiting.
// ----------------------------------------------------------------------------
module score_reel_bank_driver import srbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] amount, [35:32] reel_number, [51:36] pulse_delta, rest zero
	input  logic [55:0] s_tdata,
	// [2:0] command
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] reel_index, [6:3] digit, [22:7] pending_pulses, [23] moving,
	// [24] click, rest zero
	output logic [31:0] m_tdata,
	// [0] status
	output logic [0:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WALK   = 6'b000010,
		ST_DSTART = 6'b000100,
		ST_DWAIT  = 6'b001000,
		ST_SPIN   = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t state_q;

	logic [3:0]        reels_q;
	logic [3:0]        top_q;
	logic [STEP_W-1:0] steps_q;

	reel_t             reel_q  [MAX_REELS];
	logic              click_q [MAX_REELS];

	cmd_t                      cmd_q;
	logic                      neg_q;
	logic [AMOUNT_W-1:0]       val_q;
	logic signed [PULSE_W-1:0] delta_q;
	logic [IDX_W-1:0]          idx_q;
	logic [1:0]                carry_q;
	logic                      status_q;
	logic                      spin_ok_q;

	logic                      m_valid_q;
	logic [31:0]               m_data_q;
	logic                      m_user_q;
	logic                      m_last_q;

	logic [IDX_W-1:0]          last_idx;
	logic [BASE_W-1:0]         base;
	logic                      accept;
	logic [AMOUNT_W-1:0]       in_amount;
	logic [DIGIT_W-1:0]        in_rnum;
	logic                      div_start;
	logic                      div_done;
	logic [AMOUNT_W-1:0]       div_quot;
	logic [DIGIT_W-1:0]        div_rem;
	alu_ctrl_t                 ctrl;
	alu_res_t                  res;
	logic                      wr_en;
	logic                      out_load;

	// clamp the reel count to 1..MAX_REELS
	always_comb begin
		if (reels_q == 0)
			last_idx = '0;
		else if (reels_q > CNT_W'(MAX_REELS))
			last_idx = IDX_W'(MAX_REELS - 1);
		else
			last_idx = IDX_W'(reels_q - 1'b1);
	end

	assign base      = {1'b0, top_q} + 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_amount = s_tdata[31:0];
	assign in_rnum   = s_tdata[35:32];
	assign div_start = (state_q == ST_DSTART);
	assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	srbd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (val_q),
		.base      (base),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// drive the shared update unit from the sequencer
	always_comb begin
		ctrl       = '0;
		ctrl.carry = carry_q;
		ctrl.dv    = div_rem;
		ctrl.neg   = neg_q;
		ctrl.delta = delta_q;
		ctrl.top   = top_q;
		ctrl.base  = base;
		ctrl.steps = (steps_q == 0) ? STEP_W'(1) : steps_q;
		ctrl.op    = OP_NONE;
		wr_en      = 1'b0;
		case (state_q)
			ST_WALK: begin
				ctrl.op = (cmd_q == CMD_TICK) ? OP_TICK : OP_ZERO;
				wr_en   = 1'b1;
			end
			ST_DWAIT: begin
				ctrl.op = (cmd_q == CMD_ADD) ? OP_ADD : OP_SET;
				wr_en   = div_done;
			end
			ST_SPIN: begin
				ctrl.op = OP_SPIN;
				wr_en   = spin_ok_q;
			end
			default: begin
				ctrl.op = OP_NONE;
			end
		endcase
	end

	srbd_alu u_alu (
		.ctrl    (ctrl),
		.reel_in (reel_q[idx_q]),
		.res     (res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reels_q <= 4'd5;
			top_q   <= 4'd9;
			steps_q <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REELS_IN_USE:    reels_q <= cfg_wdata[3:0];
				REG_TOP_DIGIT:       top_q   <= cfg_wdata[3:0];
				REG_STEPS_PER_DIGIT: steps_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// reel storage and click flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_REELS; i++) begin
				reel_q[i]  <= '0;
				click_q[i] <= 1'b0;
			end
		end else begin
			if (accept) begin
				for (int i = 0; i < MAX_REELS; i++)
					click_q[i] <= 1'b0;
			end
			if (wr_en) begin
				reel_q[idx_q] <= res.reel;
				if (ctrl.op == OP_TICK)
					click_q[idx_q] <= res.click;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			carry_q   <= CARRY_NONE;
			status_q  <= 1'b0;
			spin_ok_q <= 1'b0;
			cmd_q     <= CMD_TICK;
			neg_q     <= 1'b0;
			val_q     <= '0;
			delta_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd_t'(s_tuser);
						neg_q    <= in_amount[AMOUNT_W-1];
						val_q    <= in_amount[AMOUNT_W-1] ? (AMOUNT_W'(0) - in_amount)
						                                  : in_amount;
						delta_q  <= s_tdata[51:36];
						carry_q  <= CARRY_NONE;
						status_q <= 1'b0;
						idx_q    <= last_idx;
						case (cmd_t'(s_tuser))
							CMD_TICK, CMD_ZERO: state_q <= ST_WALK;
							CMD_ADD, CMD_SET:   state_q <= ST_DSTART;
							CMD_SPIN: begin
								idx_q     <= IDX_W'(in_rnum - 1'b1);
								spin_ok_q <= (in_rnum != 0) &&
								             (in_rnum <= {1'b0, last_idx} + 1'b1);
								status_q  <= !((in_rnum != 0) &&
								             (in_rnum <= {1'b0, last_idx} + 1'b1));
								state_q   <= ST_SPIN;
							end
							default: begin
								idx_q   <= '0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_WALK: begin
					carry_q <= res.carry;
					if (idx_q == 0) begin
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						val_q <= div_quot;
						if (idx_q == 0) begin
							state_q <= ST_OUT;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= ST_DSTART;
						end
					end
				end
				ST_SPIN: begin
					idx_q   <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						if (idx_q == last_idx) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register: load a reel report, hold it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {7'b0, click_q[idx_q], (reel_q[idx_q].cnt != 0),
			             reel_q[idx_q].pulse, reel_q[idx_q].digit, idx_q};
			m_user_q <= status_q;
			m_last_q <= (idx_q == last_idx);
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;
	assign m_tlast    = m_last_q;

endmodule
